// ===== rtl/core/brs_pkg.sv =====
// Shared constants, types and register codes of the bilinear RGB sampler.
`timescale 1ns / 1ps
`default_nettype none

package brs_pkg;

  // Store geometry and coordinate format
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;

  localparam int COORD_W = 16;
  localparam int INT_W   = COORD_W - FRAC_BITS;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 1;

  localparam int X_W = $clog2(MAX_WIDTH);
  localparam int Y_W = $clog2(MAX_HEIGHT);

  // Four banks split by column and row parity
  localparam int BANK_COLS  = (MAX_WIDTH + 1) / 2;
  localparam int BANK_ROWS  = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Size registers reset to 256, kept as the largest usable index
  localparam int SIZE_RST = 256;
  localparam logic [X_W-1:0] XMAX_RST =
    X_W'(((SIZE_RST > MAX_WIDTH) ? MAX_WIDTH : SIZE_RST) - 1);
  localparam logic [Y_W-1:0] YMAX_RST =
    Y_W'(((SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RST) - 1);

  // Interpolation weights
  localparam logic [FRAC_BITS:0]   FRAC_ONE  = (FRAC_BITS + 1)'(1 << FRAC_BITS);
  localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(1 << (FRAC_BITS - 1));

  typedef logic [PIX_W-1:0]     pixel_t;
  typedef logic [FRAC_BITS-1:0] frac_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== rtl/core/bilinear_rgb_sampler.sv =====
// Top level: RGB888 pixel store with a pipelined bilinear sampler.
// One item is taken every cycle unless the output stalls. A write item stores its pixel at the
// integer part of its coordinates and gives no result; a sample item gives its interpolated
// pixel after the input register, bank read, horizontal blend and vertical blend into the
// output register. The store is split into four banks by column and row parity, each
// with one read and one write port, so the four neighbours of a sample come out in the
// same read. A stall at the output holds the whole pipeline. Size registers may only
// be written while no item is in flight; the store has no reset and unwritten pixels
// read as garbage.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_rgb_sampler (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // item input
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             kind_i,
  input  wire logic [brs_pkg::COORD_W-1:0]      coord_x_i,
  input  wire logic [brs_pkg::COORD_W-1:0]      coord_y_i,
  input  wire logic [brs_pkg::CHAN_W-1:0]       write_red_i,
  input  wire logic [brs_pkg::CHAN_W-1:0]       write_green_i,
  input  wire logic [brs_pkg::CHAN_W-1:0]       write_blue_i,
  // result output
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [brs_pkg::CHAN_W-1:0]       sample_red_o,
  output logic      [brs_pkg::CHAN_W-1:0]       sample_green_o,
  output logic      [brs_pkg::CHAN_W-1:0]       sample_blue_o,
  // configuration writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [brs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [brs_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int F    = brs_pkg::FRAC_BITS;
  localparam int CW   = brs_pkg::CHAN_W;
  localparam int IW   = brs_pkg::INT_W;
  localparam int XW   = brs_pkg::X_W;
  localparam int YW   = brs_pkg::Y_W;
  localparam int AW   = brs_pkg::BANK_AW;
  localparam int XCW  = (IW > XW) ? IW : XW;
  localparam int YCW  = (IW > YW) ? IW : YW;
  localparam int XRW  = (IW > XW + 1) ? IW : XW + 1;
  localparam int YRW  = (IW > YW + 1) ? IW : YW + 1;
  localparam int XLW  = (brs_pkg::CFG_W > XW + 1) ? brs_pkg::CFG_W : XW + 1;
  localparam int YLW  = (brs_pkg::CFG_W > YW + 1) ? brs_pkg::CFG_W : YW + 1;

  function automatic logic [AW-1:0] bank_addr(logic [XW-1:0] col, logic [YW-1:0] row);
    return AW'(row >> 1) * AW'(brs_pkg::BANK_COLS) + AW'(col >> 1);
  endfunction

  // ---------------------------------------------------------------- config
  logic [XW-1:0] xmax_q, xmax_d;
  logic [YW-1:0] ymax_q, ymax_d;
  logic [XLW-1:0] cfg_vx;
  logic [YLW-1:0] cfg_vy;

  assign cfg_ready_o = 1'b1;
  assign cfg_vx = XLW'(cfg_data_i);
  assign cfg_vy = YLW'(cfg_data_i);

  always_comb begin
    xmax_d = xmax_q;
    ymax_d = ymax_q;
    if (cfg_valid_i) begin
      unique case (brs_pkg::cfg_reg_e'(cfg_index_i))
        brs_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_vx == '0) begin
            xmax_d = '0;
          end else if (cfg_vx > XLW'(brs_pkg::MAX_WIDTH)) begin
            xmax_d = XW'(brs_pkg::MAX_WIDTH - 1);
          end else begin
            xmax_d = XW'(cfg_vx - XLW'(1));
          end
        end
        brs_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg_vy == '0) begin
            ymax_d = '0;
          end else if (cfg_vy > YLW'(brs_pkg::MAX_HEIGHT)) begin
            ymax_d = YW'(brs_pkg::MAX_HEIGHT - 1);
          end else begin
            ymax_d = YW'(cfg_vy - YLW'(1));
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmax_q <= brs_pkg::XMAX_RST;
      ymax_q <= brs_pkg::YMAX_RST;
    end else begin
      xmax_q <= xmax_d;
      ymax_q <= ymax_d;
    end
  end

  // ---------------------------------------------------------------- pipeline control
  logic pipe_adv;
  logic out_valid_q;

  assign pipe_adv   = !(out_valid_q && out_stall_i);
  assign in_stall_o = !pipe_adv;

  // ---------------------------------------------------------------- stage 1: input register
  logic                        s1_valid_q;
  logic                        s1_kind_q;
  logic [brs_pkg::COORD_W-1:0] s1_cx_q;
  logic [brs_pkg::COORD_W-1:0] s1_cy_q;
  brs_pkg::pixel_t             s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pipe_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s1_kind_q <= kind_i;
      s1_cx_q   <= coord_x_i;
      s1_cy_q   <= coord_y_i;
      s1_pix_q  <= {write_blue_i, write_green_i, write_red_i};
    end
  end

  // clamp to the image and find the neighbours
  logic [XCW-1:0] cx_int;
  logic [YCW-1:0] cy_int;
  brs_pkg::frac_t cx_frac, cy_frac;
  logic           x_over, y_over;
  logic [XW-1:0]  lx, hx;
  logic [YW-1:0]  ly, hy;
  brs_pkg::frac_t fx, fy;

  assign cx_int  = XCW'(s1_cx_q[brs_pkg::COORD_W-1:F]);
  assign cy_int  = YCW'(s1_cy_q[brs_pkg::COORD_W-1:F]);
  assign cx_frac = s1_cx_q[F-1:0];
  assign cy_frac = s1_cy_q[F-1:0];

  assign x_over = (cx_int > XCW'(xmax_q)) || ((cx_int == XCW'(xmax_q)) && (cx_frac != '0));
  assign y_over = (cy_int > YCW'(ymax_q)) || ((cy_int == YCW'(ymax_q)) && (cy_frac != '0));

  assign lx = x_over ? xmax_q : cx_int[XW-1:0];
  assign ly = y_over ? ymax_q : cy_int[YW-1:0];
  assign fx = x_over ? '0 : cx_frac;
  assign fy = y_over ? '0 : cy_frac;
  assign hx = (fx != '0) ? lx + XW'(1) : lx;
  assign hy = (fy != '0) ? ly + YW'(1) : ly;

  // pixel writes
  logic          wr_ok;
  logic [XW-1:0] wr_x;
  logic [YW-1:0] wr_y;
  logic [AW-1:0] wr_addr;
  logic          rd_go;

  assign wr_ok = pipe_adv && s1_valid_q && !s1_kind_q &&
                 (XRW'(s1_cx_q[brs_pkg::COORD_W-1:F]) < XRW'(brs_pkg::MAX_WIDTH)) &&
                 (YRW'(s1_cy_q[brs_pkg::COORD_W-1:F]) < YRW'(brs_pkg::MAX_HEIGHT));
  assign wr_x    = cx_int[XW-1:0];
  assign wr_y    = cy_int[YW-1:0];
  assign wr_addr = bank_addr(wr_x, wr_y);
  assign rd_go   = pipe_adv && s1_valid_q && s1_kind_q;

  logic [3:0]      bank_we;
  brs_pkg::pixel_t bank_rdata [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] Sel = 2'(b);
    logic [XW-1:0] col;
    logic [YW-1:0] row;

    // each bank serves whichever neighbour has its parity
    assign col = (lx[0] == Sel[0]) ? lx : hx;
    assign row = (ly[0] == Sel[1]) ? ly : hy;
    assign bank_we[b] = wr_ok && ({wr_y[0], wr_x[0]} == Sel);

    brs_ram #(
      .WIDTH (brs_pkg::PIX_W),
      .DEPTH (brs_pkg::BANK_DEPTH)
    ) u_ram (
      .clk_i     (clk_i),
      .wr_en_i   (bank_we[b]),
      .wr_addr_i (wr_addr),
      .wr_data_i (s1_pix_q),
      .rd_en_i   (rd_go),
      .rd_addr_i (bank_addr(col, row)),
      .rd_data_o (bank_rdata[b])
    );
  end

  // ---------------------------------------------------------------- stage 2: bank read data
  logic           s2_valid_q;
  logic           s2_lx0_q, s2_ly0_q;
  brs_pkg::frac_t s2_fx_q, s2_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (pipe_adv) begin
      s2_valid_q <= s1_valid_q && s1_kind_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s2_lx0_q <= lx[0];
      s2_ly0_q <= ly[0];
      s2_fx_q  <= fx;
      s2_fy_q  <= fy;
    end
  end

  brs_pkg::pixel_t top_pix, bot_pix;

  brs_lerp u_lerp_top (
    .lo_i   (bank_rdata[{s2_ly0_q, s2_lx0_q}]),
    .hi_i   (bank_rdata[{s2_ly0_q, !s2_lx0_q}]),
    .frac_i (s2_fx_q),
    .pix_o  (top_pix)
  );

  brs_lerp u_lerp_bot (
    .lo_i   (bank_rdata[{!s2_ly0_q, s2_lx0_q}]),
    .hi_i   (bank_rdata[{!s2_ly0_q, !s2_lx0_q}]),
    .frac_i (s2_fx_q),
    .pix_o  (bot_pix)
  );

  // ---------------------------------------------------------------- stage 3: row blends
  logic            s3_valid_q;
  brs_pkg::pixel_t s3_top_q, s3_bot_q;
  brs_pkg::frac_t  s3_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (pipe_adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s3_top_q <= top_pix;
      s3_bot_q <= bot_pix;
      s3_fy_q  <= s2_fy_q;
    end
  end

  brs_pkg::pixel_t res_pix;

  brs_lerp u_lerp_vert (
    .lo_i   (s3_top_q),
    .hi_i   (s3_bot_q),
    .frac_i (s3_fy_q),
    .pix_o  (res_pix)
  );

  // ---------------------------------------------------------------- output register
  brs_pkg::pixel_t out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_adv) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      out_pix_q <= res_pix;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_red_o   = out_pix_q[0*CW +: CW];
  assign sample_green_o = out_pix_q[1*CW +: CW];
  assign sample_blue_o  = out_pix_q[2*CW +: CW];

  // ---------------------------------------------------------------- assertions
  a_hi_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_kind_q && (fx != '0)) |-> (lx < xmax_q))
    else $error("high column neighbour beyond image");

  a_hi_row_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_kind_q && (fy != '0)) |-> (ly < ymax_q))
    else $error("high row neighbour beyond image");

  a_one_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bank_we) && !(wr_ok && rd_go))
    else $error("conflicting store accesses");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> ($stable(s3_valid_q) && $stable(s2_valid_q)))
    else $error("pipeline moved under output stall");

  a_out_from_s3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s3_valid_q))
    else $error("result without a finished sample");

endmodule

`default_nettype wire

// ===== rtl/core/brs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module brs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/brs_lerp.sv =====
// One-axis linear blend of two RGB888 pixels with rounded, saturating channels.
`timescale 1ns / 1ps
`default_nettype none

module brs_lerp (
  input  wire brs_pkg::pixel_t lo_i,
  input  wire brs_pkg::pixel_t hi_i,
  input  wire brs_pkg::frac_t  frac_i,
  output brs_pkg::pixel_t      pix_o
);

  localparam int F    = brs_pkg::FRAC_BITS;
  localparam int CW   = brs_pkg::CHAN_W;
  localparam int PW   = CW + F + 1;
  localparam int QW   = PW - F;

  // p * w / 2^F, round to nearest, ties to even
  function automatic logic [QW-1:0] weigh(logic [CW-1:0] p, logic [F:0] w);
    logic [PW-1:0] prod;
    logic [QW-1:0] q;
    logic [F-1:0]  r;
    logic          up;
    prod = PW'(p) * PW'(w);
    q    = prod[PW-1:F];
    r    = prod[F-1:0];
    up   = (r > brs_pkg::FRAC_HALF) || ((r == brs_pkg::FRAC_HALF) && q[0]);
    return q + QW'(up);
  endfunction

  logic [F:0] w_hi;
  logic [F:0] w_lo;

  assign w_hi = {1'b0, frac_i};
  assign w_lo = brs_pkg::FRAC_ONE - w_hi;

  always_comb begin
    logic [QW:0] sum;
    pix_o = lo_i;
    for (int c = 0; c < 3; c++) begin
      sum = (QW + 1)'(weigh(hi_i[c*CW +: CW], w_hi)) +
            (QW + 1)'(weigh(lo_i[c*CW +: CW], w_lo));
      // zero fraction takes the low pixel untouched
      if (frac_i != '0) begin
        pix_o[c*CW +: CW] = (sum > (QW + 1)'(255)) ? CW'(255) : sum[CW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== test/brs_checker.sv =====
// Item-kind codes and the result checker for the bilinear RGB sampler testbench.
`timescale 1ns / 1ps

package brs_item_pkg;
  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SAMPLE = 1'b1
  } item_kind_e;
endpackage

module brs_checker
  import brs_pkg::*;
  import brs_item_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_i,
  input  wire logic                kind_i,
  input  wire logic [COORD_W-1:0]  coord_x_i,
  input  wire logic [COORD_W-1:0]  coord_y_i,
  input  wire logic [CHAN_W-1:0]   write_red_i,
  input  wire logic [CHAN_W-1:0]   write_green_i,
  input  wire logic [CHAN_W-1:0]   write_blue_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_stall_i,
  input  wire logic [CHAN_W-1:0]   sample_red_i,
  input  wire logic [CHAN_W-1:0]   sample_green_i,
  input  wire logic [CHAN_W-1:0]   sample_blue_i,
  input  wire logic                cfg_valid_i,
  input  wire logic                cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  rgb_t             img_mem [MAX_WIDTH*MAX_HEIGHT];
  rgb_t             sample_q [$];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int               mismatches;

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic int unsigned size_in_use(logic [CFG_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // p * w / 2^FRAC_BITS, round half to even, clipped to a byte
  function automatic logic [CHAN_W-1:0] scale_round(logic [CHAN_W-1:0] p,
                                                    logic [FRAC_BITS:0] w);
    logic [CHAN_W+FRAC_BITS:0] prod;
    logic [CHAN_W:0]           q;
    prod = p * w;
    q    = prod[CHAN_W+FRAC_BITS:FRAC_BITS];
    if (prod[FRAC_BITS-1:0] > FRAC_HALF || (prod[FRAC_BITS-1:0] == FRAC_HALF && q[0]))
      q = q + 1'b1;
    return (q > 255) ? '1 : q[CHAN_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] mix_chan(logic [CHAN_W-1:0] lo, logic [CHAN_W-1:0] hi,
                                                 frac_t f);
    logic [CHAN_W:0] sum;
    sum = scale_round(hi, {1'b0, f}) + scale_round(lo, FRAC_ONE - f);
    return (sum > 255) ? '1 : sum[CHAN_W-1:0];
  endfunction

  function automatic rgb_t mix_px(rgb_t lo, rgb_t hi, frac_t f);
    rgb_t r;
    r.red   = mix_chan(lo.red, hi.red, f);
    r.green = mix_chan(lo.green, hi.green, f);
    r.blue  = mix_chan(lo.blue, hi.blue, f);
    return r;
  endfunction

  function automatic rgb_t stored_px(int unsigned x, int unsigned y);
    return img_mem[y * MAX_WIDTH + x];
  endfunction

  function automatic rgb_t sample_at(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    int unsigned lim_x, lim_y, lx, ly, hx, hy;
    frac_t       fx, fy;
    rgb_t        top_px, bot_px;
    lim_x = (size_in_use(width_reg, MAX_WIDTH) - 1) << FRAC_BITS;
    lim_y = (size_in_use(height_reg, MAX_HEIGHT) - 1) << FRAC_BITS;
    // beyond the last column or row: pinned there with no fraction
    if (cx > lim_x) cx = COORD_W'(lim_x);
    if (cy > lim_y) cy = COORD_W'(lim_y);
    lx = cx >> FRAC_BITS;
    ly = cy >> FRAC_BITS;
    fx = cx[FRAC_BITS-1:0];
    fy = cy[FRAC_BITS-1:0];
    hx = (fx != '0) ? lx + 1 : lx;
    hy = (fy != '0) ? ly + 1 : ly;
    if (fx == '0) begin
      top_px = stored_px(lx, ly);
      bot_px = stored_px(lx, hy);
    end else begin
      top_px = mix_px(stored_px(lx, ly), stored_px(hx, ly), fx);
      bot_px = mix_px(stored_px(lx, hy), stored_px(hx, hy), fx);
    end
    return (fy == '0) ? top_px : mix_px(top_px, bot_px, fy);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t        got, want;
    int unsigned wx, wy;
    if (!rst_ni) begin
      width_reg  = CFG_W'(SIZE_RST);
      height_reg = CFG_W'(SIZE_RST);
      sample_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{blue: sample_blue_i, green: sample_green_i, red: sample_red_i};
        if (sample_q.size() == 0) begin
          report_mismatch("result transfer with no sample outstanding, red", got.red, 0);
        end else begin
          want = sample_q.pop_front();
          if (got.red != want.red)     report_mismatch("sample_red", got.red, want.red);
          if (got.green != want.green) report_mismatch("sample_green", got.green, want.green);
          if (got.blue != want.blue)   report_mismatch("sample_blue", got.blue, want.blue);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_IMAGE_WIDTH:  width_reg  = cfg_data_i;
          REG_IMAGE_HEIGHT: height_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == KIND_SAMPLE) begin
          sample_q.push_back(sample_at(coord_x_i, coord_y_i));
        end else begin
          wx = coord_x_i >> FRAC_BITS;
          wy = coord_y_i >> FRAC_BITS;
          if (wx < MAX_WIDTH && wy < MAX_HEIGHT)
            img_mem[wy * MAX_WIDTH + wx] =
              '{blue: write_blue_i, green: write_green_i, red: write_red_i};
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= sample_q.size();
    end
  end

endmodule

// ===== test/bilinear_rgb_sampler_tb.sv =====
// Stimulus and verdict for the bilinear RGB sampler: reset, size phases, pixel and sample items.
`timescale 1ns / 1ps

module bilinear_rgb_sampler_tb;
  import brs_pkg::*;
  import brs_item_pkg::*;

  localparam int N_PHASES     = 8;
  localparam int RANDOM_PHASE = 6;
  localparam int PAUSE_PHASE  = 4;
  localparam logic [CFG_W-1:0] PHASE_W [N_PHASES] =
    '{9'd511, 9'd1, 9'd0, 9'd2, 9'd300, 9'd5, 9'd0, 9'd256};
  localparam logic [CFG_W-1:0] PHASE_H [N_PHASES] =
    '{9'd511, 9'd1, 9'd3, 9'd0, 9'd7, 9'd256, 9'd0, 9'd256};

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               kind      = KIND_WRITE;
  logic [COORD_W-1:0] coord_x   = '0;
  logic [COORD_W-1:0] coord_y   = '0;
  logic [CHAN_W-1:0]  wr_red    = '0;
  logic [CHAN_W-1:0]  wr_green  = '0;
  logic [CHAN_W-1:0]  wr_blue   = '0;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  cfg_reg_e           cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]   cfg_data  = '0;

  wire logic              in_stall;
  wire logic              out_valid;
  wire logic [CHAN_W-1:0] smp_red, smp_green, smp_blue;
  wire logic              cfg_ready;

  int          fail_count;
  int          pending;
  logic        calm = 1'b0;
  bit          quiet;
  bit          written [MAX_WIDTH*MAX_HEIGHT];
  int unsigned cols = 256;
  int unsigned rows = 256;
  int unsigned stall_left = 0;
  int          n_writes, n_samples, n_settings;

  always #2 clk = ~clk;

  bilinear_rgb_sampler uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .coord_x_i      (coord_x),
    .coord_y_i      (coord_y),
    .write_red_i    (wr_red),
    .write_green_i  (wr_green),
    .write_blue_i   (wr_blue),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sample_red_o   (smp_red),
    .sample_green_o (smp_green),
    .sample_blue_o  (smp_blue),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  brs_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .kind_i         (kind),
    .coord_x_i      (coord_x),
    .coord_y_i      (coord_y),
    .write_red_i    (wr_red),
    .write_green_i  (wr_green),
    .write_blue_i   (wr_blue),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .sample_red_i   (smp_red),
    .sample_green_i (smp_green),
    .sample_blue_i  (smp_blue),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 4);
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned size_in_use(logic [CFG_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic frac_t pick_frac();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return FRAC_HALF;
      2:       return '1;
      default: return frac_t'($urandom);
    endcase
  endfunction

  task automatic send(input logic k, input logic [COORD_W-1:0] cx, cy,
                      input logic [CHAN_W-1:0] r, g, b);
    if (!calm && !quiet && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    coord_x  <= cx;
    coord_y  <= cy;
    wr_red   <= r;
    wr_green <= g;
    wr_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender until every sample has been answered and writes have retired
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
    cols = size_in_use(w, MAX_WIDTH);
    rows = size_in_use(h, MAX_HEIGHT);
    n_settings++;
  endtask

  task automatic put_pixel(int unsigned x, int unsigned y, logic [CHAN_W-1:0] r, g, b);
    written[y * MAX_WIDTH + x] = 1'b1;
    n_writes++;
    send(KIND_WRITE, {x[INT_W-1:0], frac_t'($urandom)}, {y[INT_W-1:0], frac_t'($urandom)},
         r, g, b);
  endtask

  task automatic fill_if_empty(int unsigned x, int unsigned y);
    if (!written[y * MAX_WIDTH + x])
      put_pixel(x, y, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  // every neighbour a sample reads is written first, so no undefined pixel is ever read
  task automatic take_sample(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    int unsigned ux, uy, lx, ly, hx, hy;
    ux = cx;
    uy = cy;
    if (ux > ((cols - 1) << FRAC_BITS)) ux = (cols - 1) << FRAC_BITS;
    if (uy > ((rows - 1) << FRAC_BITS)) uy = (rows - 1) << FRAC_BITS;
    lx = ux >> FRAC_BITS;
    ly = uy >> FRAC_BITS;
    hx = (ux[FRAC_BITS-1:0] != '0) ? lx + 1 : lx;
    hy = (uy[FRAC_BITS-1:0] != '0) ? ly + 1 : ly;
    fill_if_empty(lx, ly);
    fill_if_empty(hx, ly);
    fill_if_empty(lx, hy);
    fill_if_empty(hx, hy);
    n_samples++;
    send(KIND_SAMPLE, cx, cy, $urandom_range(0, 255), $urandom_range(0, 255),
         $urandom_range(0, 255));
  endtask

  initial begin
    int unsigned        win_x, win_y, xi, yi, mode;
    logic [CFG_W-1:0]   w, h;
    logic [COORD_W-1:0] cx, cy;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners, ties, saturation, single-axis fractions, clamping
    put_pixel(0, 0, 8'hFF, 8'hFF, 8'hFF);
    put_pixel(1, 0, 8'hFF, 8'hFF, 8'hFF);
    put_pixel(0, 1, 8'h00, 8'h00, 8'h00);
    put_pixel(1, 1, 8'h80, 8'h01, 8'hFE);
    put_pixel(255, 255, 8'h12, 8'h34, 8'h56);
    take_sample(16'h0000, 16'h0000);
    take_sample(16'h0080, 16'h0000);
    take_sample(16'h0080, 16'h0080);
    take_sample(16'h00FF, 16'h0001);
    take_sample(16'h0001, 16'h00FF);
    take_sample(16'h0000, 16'h0080);
    take_sample(16'h0040, 16'h00C0);
    take_sample(16'hFFFF, 16'hFFFF);
    take_sample(16'hFF80, 16'hFE80);
    take_sample(16'h1234, 16'hFFFF);
    put_pixel(0, 0, 8'h00, 8'h00, 8'h00);
    take_sample(16'h0080, 16'h0000);
    put_pixel(1, 0, 8'h01, 8'hFF, 8'h7F);
    take_sample(16'h00C0, 16'h0000);

    for (int p = 0; p < N_PHASES; p++) begin
      w = PHASE_W[p];
      h = PHASE_H[p];
      if (p == RANDOM_PHASE) begin
        w = $urandom_range(1, 256);
        h = $urandom_range(1, 256);
      end
      set_size(w, h);
      quiet = ($urandom_range(0, 3) == 0);
      if (p == N_PHASES - 1) begin
        calm  <= 1'b1;
        quiet = 1'b1;
      end
      for (int i = 0; i < 100; i++) begin
        if (i % 25 == 0) begin
          win_x = $urandom_range(0, cols - 1);
          win_y = $urandom_range(0, rows - 1);
        end
        if (p == PAUSE_PHASE && i == 50) drain();
        if ($urandom_range(0, 3) == 0) begin
          put_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
        end else begin
          mode = $urandom_range(0, 19);
          if (mode < 12) begin
            // small window: neighbours get reused and overwritten
            xi = win_x + $urandom_range(0, 5);
            yi = win_y + $urandom_range(0, 5);
            if (xi > 255) xi = 255;
            if (yi > 255) yi = 255;
            cx = {xi[INT_W-1:0], pick_frac()};
            cy = {yi[INT_W-1:0], pick_frac()};
          end else if (mode < 17) begin
            xi = $urandom_range(0, cols - 1);
            yi = $urandom_range(0, rows - 1);
            cx = {xi[INT_W-1:0], pick_frac()};
            cy = {yi[INT_W-1:0], pick_frac()};
          end else begin
            cx = COORD_W'($urandom);
            cy = COORD_W'($urandom);
          end
          take_sample(cx, cy);
        end
      end
    end

    drain();
    $display("Covered %0d pixel writes and %0d samples across %0d image size settings,",
             n_writes, n_samples, n_settings);
    $display("from 1x1 up to 256x256 with out-of-range sizes, clamped and fractional coordinates.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
